// ----- design/crawl_gait_spline_generator_core_macros.svh -----
// Assertion macros used by the core design file.
`ifndef CRAWL_GAIT_SPLINE_GENERATOR_CORE_MACROS_SVH
`define CRAWL_GAIT_SPLINE_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CGSG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CGSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CGSG_ASSERT_IMP(lbl, ante, cons, msg)
`define CGSG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/cgsg_pkg.sv -----
`timescale 1ns / 1ps
package cgsg_pkg;

    localparam int JOINTS_DEF = 12;
    localparam int KEY_FRAMES = 5;
    localparam int SEGS       = KEY_FRAMES - 1;

    localparam int DIV_NW = 38;
    localparam int DIV_DW = 16;
    localparam int MA_W   = 22;
    localparam int MB_W   = 17;
    localparam int MP_W   = MA_W + MB_W;
    localparam int ACC_W  = 40;
    localparam int Q_W    = 22;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic [2:0] CFG_ALIGN = 3'd0;
    localparam logic [2:0] CFG_RAMP  = 3'd1;
    localparam logic [2:0] CFG_TROT  = 3'd2;
    localparam logic [2:0] CFG_STIFF = 3'd3;
    localparam logic [2:0] CFG_DAMP  = 3'd4;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_ALIGN = 3'd1,
        PH_TRANS = 3'd2,
        PH_TROT  = 3'd3,
        PH_DONE  = 3'd4,
        PH_IDLE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

    localparam logic signed [15:0] STAND_TAB [0:11] = '{
        16'sd0, 16'sd4710, -16'sd9421, 16'sd0, 16'sd4710, -16'sd9421,
        -16'sd819, 16'sd4710, -16'sd9421, 16'sd819, 16'sd4710, -16'sd9421
    };

    localparam logic signed [15:0] KEY_TAB [0:11][0:4] = '{
        '{16'sd0, -16'sd819, -16'sd1229, -16'sd410, 16'sd0},
        '{16'sd4710, 16'sd8069, 16'sd5325, 16'sd3645, 16'sd4710},
        '{-16'sd9421, -16'sd9830, -16'sd11059, -16'sd9708, -16'sd9421},
        '{16'sd1229, 16'sd410, 16'sd0, 16'sd819, 16'sd1229},
        '{16'sd5325, 16'sd3645, 16'sd4710, 16'sd8069, 16'sd5325},
        '{-16'sd11059, -16'sd9708, -16'sd9421, -16'sd9830, -16'sd11059},
        '{-16'sd1229, -16'sd410, 16'sd0, -16'sd819, -16'sd1229},
        '{16'sd5325, 16'sd3645, 16'sd4710, 16'sd8069, 16'sd5325},
        '{-16'sd11059, -16'sd9708, -16'sd9421, -16'sd9830, -16'sd11059},
        '{16'sd0, 16'sd819, 16'sd1229, 16'sd410, 16'sd0},
        '{16'sd4710, 16'sd8069, 16'sd5325, 16'sd3645, 16'sd4710},
        '{-16'sd9421, -16'sd9830, -16'sd11059, -16'sd9708, -16'sd9421}
    };

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -24'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/cgsg_div.sv -----
`timescale 1ns / 1ps
module cgsg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cgsg_pkg::div_req_t req,
    output cgsg_pkg::div_rsp_t rsp
);
    localparam int NW    = cgsg_pkg::DIV_NW;
    localparam int DW    = cgsg_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg, rem_reg;
    logic [DW:0]      rem_sh;
    logic [DW+1:0]    diff;

    // One quotient bit per cycle, restoring.
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;
endmodule

// ----- design/cgsg_mul.sv -----
`timescale 1ns / 1ps
module cgsg_mul (
    input  logic                                clk,
    input  logic signed [cgsg_pkg::MA_W-1:0]    a,
    input  logic signed [cgsg_pkg::MB_W-1:0]    b,
    output logic signed [cgsg_pkg::MP_W-1:0]    prod
);
    logic signed [cgsg_pkg::MP_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= cgsg_pkg::MP_W'(a) * cgsg_pkg::MP_W'(b);
    end

    assign prod = prod_reg;
endmodule

// ----- design/crawl_gait_spline_generator_core.sv -----
`timescale 1ns / 1ps
// Sample, start, unused and non-commanding tick items are handled in the idle state; a done tick also passes
// through the emit state. A commanded tick emits one beat per joint, and transition and trot ticks first
// find the segment and fraction; the shared radix-2 divider performs every division of a tick.
// Output stalls lengthen a tick; a new item is taken once the last beat of the tick is loaded.
// Reset clears the phase, counters, sample mask and output valid and loads the
// register defaults; the angle stores hold no value until written.
`include "crawl_gait_spline_generator_core_macros.svh"
module crawl_gait_spline_generator_core #(
    parameter int JOINTS = cgsg_pkg::JOINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [3:0]         joint_index,
    input  logic signed [15:0] measured_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         joint_number,
    output logic signed [15:0] target_angle,
    output logic [15:0]        stiffness,
    output logic [15:0]        damping,
    output logic [2:0]         phase,
    output logic               finished,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int JW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int MA_W = cgsg_pkg::MA_W;
    localparam int MB_W = cgsg_pkg::MB_W;
    localparam int MP_W = cgsg_pkg::MP_W;
    localparam int NW   = cgsg_pkg::DIV_NW;
    localparam int ACC_W = cgsg_pkg::ACC_W;
    localparam int Q_W  = cgsg_pkg::Q_W;
    localparam int KF   = cgsg_pkg::KEY_FRAMES;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_DIVW = 15'b000000000000010,
        S_U2   = 15'b000000000000100,
        S_U3   = 15'b000000000001000,
        S_UL   = 15'b000000000010000,
        S_C1   = 15'b000000000100000,
        S_C2   = 15'b000000001000000,
        S_C3   = 15'b000000010000000,
        S_C4   = 15'b000000100000000,
        S_CQ   = 15'b000001000000000,
        S_RMUL = 15'b000010000000000,
        S_RDIV = 15'b000100000000000,
        S_AMUL = 15'b001000000000000,
        S_ADIV = 15'b010000000000000,
        S_EMIT = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        OP_MOD   = 3'd0,
        OP_SEG   = 3'd1,
        OP_FRAC  = 3'd2,
        OP_ALIGN = 3'd3,
        OP_RAMP  = 3'd4
    } div_op_t;

    state_t state_reg, state_next;
    div_op_t op_reg, op_next;
    cgsg_pkg::phase_t phase_reg, phase_next, ph_cur_reg, ph_cur_next;

    logic [15:0] align_ticks_reg, ramp_ticks_reg, trot_ticks_reg, stiff_reg, damp_reg;
    logic [15:0] align_step_reg, align_step_next, ramp_step_reg, ramp_step_next;
    logic [15:0] trot_step_reg, trot_step_next;
    logic [2:0]  cycle_count_reg, cycle_count_next;
    logic [JOINTS-1:0] mask_reg, mask_next;
    logic [JW-1:0] j_reg, j_next;
    logic        fin_reg, fin_next, neg_reg, neg_next;
    logic [15:0] rs_reg, rs_next, uq_reg, uq_next, u2_reg, u2_next, u3_reg, u3_next;
    logic [2:0]  seg_reg, seg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [Q_W-1:0]   q_reg, q_next;
    logic signed [15:0] res_reg, res_next;

    logic out_valid_reg, out_valid_next;
    logic [3:0] out_joint_reg, out_joint_next;
    logic signed [15:0] out_angle_reg, out_angle_next;
    logic [15:0] out_stiff_reg, out_stiff_next, out_damp_reg, out_damp_next;
    logic [2:0] out_phase_reg, out_phase_next;
    logic out_fin_reg, out_fin_next, out_last_reg, out_last_next;

    logic signed [15:0] measured_store_reg [JOINTS];
    logic signed [15:0] start_pose_reg [JOINTS];
    logic store_we, capture;

    cgsg_pkg::div_req_t div_req;
    cgsg_pkg::div_rsp_t div_rsp;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;

    logic [15:0] t_eff, r_eff, p_eff;
    logic        accept_in;
    logic [3:0]  jj, jrow;
    logic [3:0]  k0, k1, k2, k3;
    logic [2:0]  c0i, c1i, c2i, c3i;
    logic signed [MA_W-1:0] p0, p1, p2, p3, cf1, cf2, cf3, b_st, a_po;
    logic [16:0] s_inc, ramp_inc;
    logic [15:0] s_val;
    logic [2:0]  cc_tmp;
    logic [MP_W-1:0] abs_prod;
    logic [ACC_W-1:0] abs_acc, rnd_acc;
    logic signed [Q_W-1:0] q_val;
    logic signed [23:0] quo_s, sum_v;
    logic [15:0] den_sel;

    function automatic logic [2:0] col_of(input logic [3:0] k);
        logic [3:0] c;
        c = (k >= 4'd5) ? k - 4'd5 : k;
        return c[2:0];
    endfunction

    cgsg_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    cgsg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .prod(prod)
    );

    assign t_eff = (align_ticks_reg == 16'd0) ? 16'd1 : align_ticks_reg;
    assign r_eff = (ramp_ticks_reg == 16'd0) ? 16'd1 : ramp_ticks_reg;
    assign p_eff = (trot_ticks_reg == 16'd0) ? 16'd1 : trot_ticks_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Key frame lookups for the current segment and joint.
    assign jj   = 4'(j_reg);
    assign jrow = (jj >= 4'd12) ? jj - 4'd12 : jj;
    assign k1   = {1'b0, seg_reg};
    assign k0   = (k1 + 4'(KF - 1) >= 4'(KF)) ? k1 + 4'(KF - 1) - 4'(KF) : k1 + 4'(KF - 1);
    assign k2   = (k1 + 4'd1 >= 4'(KF)) ? k1 + 4'd1 - 4'(KF) : k1 + 4'd1;
    assign k3   = (k1 + 4'd2 >= 4'(KF)) ? k1 + 4'd2 - 4'(KF) : k1 + 4'd2;
    assign c0i  = col_of(k0);
    assign c1i  = col_of(k1);
    assign c2i  = col_of(k2);
    assign c3i  = col_of(k3);
    assign p0   = MA_W'(cgsg_pkg::KEY_TAB[jrow][c0i]);
    assign p1   = MA_W'(cgsg_pkg::KEY_TAB[jrow][c1i]);
    assign p2   = MA_W'(cgsg_pkg::KEY_TAB[jrow][c2i]);
    assign p3   = MA_W'(cgsg_pkg::KEY_TAB[jrow][c3i]);
    assign cf1  = p2 - p0;
    assign cf2  = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    assign cf3  = (p1 <<< 1) + p1 - p0 - (p2 <<< 1) - p2 + p3;
    assign b_st = MA_W'(cgsg_pkg::STAND_TAB[jrow]);
    assign a_po = MA_W'(start_pose_reg[j_reg]);

    assign s_inc    = {1'b0, align_step_reg} + 17'd1;
    assign s_val    = (s_inc > {1'b0, t_eff}) ? t_eff : s_inc[15:0];
    assign ramp_inc = (ramp_step_reg == 16'hffff) ? 17'h0ffff : {1'b0, ramp_step_reg} + 17'd1;

    // Round the spline sum by 2^17, ties away from zero.
    assign abs_acc = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rnd_acc = (abs_acc + ACC_W'(65536)) >> 17;
    assign q_val   = acc_reg[ACC_W-1] ? -Q_W'(rnd_acc) : Q_W'(rnd_acc);

    assign abs_prod = prod[MP_W-1] ? MP_W'(-prod) : MP_W'(prod);
    assign quo_s    = neg_reg ? -$signed({1'b0, div_rsp.quo[22:0]})
                              : $signed({1'b0, div_rsp.quo[22:0]});
    assign den_sel  = (state_reg == S_ADIV) ? t_eff : r_eff;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        phase_next       = phase_reg;
        ph_cur_next      = ph_cur_reg;
        align_step_next  = align_step_reg;
        ramp_step_next   = ramp_step_reg;
        trot_step_next   = trot_step_reg;
        cycle_count_next = cycle_count_reg;
        mask_next        = mask_reg;
        j_next           = j_reg;
        fin_next         = fin_reg;
        neg_next         = neg_reg;
        rs_next          = rs_reg;
        uq_next          = uq_reg;
        u2_next          = u2_reg;
        u3_next          = u3_reg;
        seg_next         = seg_reg;
        acc_next         = acc_reg;
        q_next           = q_reg;
        res_next         = res_reg;
        store_we         = 1'b0;
        capture          = 1'b0;
        cc_tmp           = cycle_count_reg;
        sum_v            = '0;
        div_req.start    = 1'b0;
        div_req.num      = '0;
        div_req.den      = p_eff;
        mul_a            = '0;
        mul_b            = '0;

        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_joint_next = out_joint_reg;
        out_angle_next = out_angle_reg;
        out_stiff_next = out_stiff_reg;
        out_damp_next  = out_damp_reg;
        out_phase_next = out_phase_reg;
        out_fin_next   = out_fin_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    case (kind)
                        cgsg_pkg::KIND_SAMPLE:
                        begin
                            if ({1'b0, joint_index} < 5'(JOINTS))
                            begin
                                store_we = 1'b1;
                                mask_next[joint_index[JW-1:0]] = 1'b1;
                            end
                        end
                        cgsg_pkg::KIND_START:
                        begin
                            phase_next       = cgsg_pkg::PH_WAIT;
                            align_step_next  = '0;
                            ramp_step_next   = '0;
                            trot_step_next   = '0;
                            cycle_count_next = '0;
                        end
                        cgsg_pkg::KIND_TICK:
                        begin
                            case (phase_reg)
                                cgsg_pkg::PH_WAIT:
                                begin
                                    if (&mask_reg)
                                    begin
                                        capture         = 1'b1;
                                        align_step_next = '0;
                                        phase_next      = cgsg_pkg::PH_ALIGN;
                                    end
                                end
                                cgsg_pkg::PH_ALIGN:
                                begin
                                    align_step_next = s_val;
                                    if (s_val >= t_eff)
                                    begin
                                        phase_next     = cgsg_pkg::PH_TRANS;
                                        ramp_step_next = '0;
                                        trot_step_next = '0;
                                    end
                                    ph_cur_next = cgsg_pkg::PH_ALIGN;
                                    fin_next    = 1'b0;
                                    j_next      = '0;
                                    state_next  = S_AMUL;
                                end
                                cgsg_pkg::PH_TRANS, cgsg_pkg::PH_TROT:
                                begin
                                    if (phase_reg == cgsg_pkg::PH_TRANS)
                                    begin
                                        ramp_step_next = ramp_inc[15:0];
                                        rs_next = (ramp_inc[15:0] < r_eff) ? ramp_inc[15:0] : r_eff;
                                        if (ramp_inc[15:0] >= r_eff)
                                        begin
                                            phase_next = cgsg_pkg::PH_TROT;
                                        end
                                    end
                                    ph_cur_next   = phase_reg;
                                    fin_next      = 1'b0;
                                    div_req.start = 1'b1;
                                    div_req.num   = NW'({1'b0, trot_step_reg} + 17'd1);
                                    op_next       = OP_MOD;
                                    state_next    = S_DIVW;
                                end
                                cgsg_pkg::PH_DONE:
                                begin
                                    fin_next    = 1'b1;
                                    ph_cur_next = cgsg_pkg::PH_DONE;
                                    phase_next  = cgsg_pkg::PH_IDLE;
                                    state_next  = S_EMIT;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    case (op_reg)
                        OP_MOD:
                        begin
                            trot_step_next = div_rsp.rem;
                            if (ph_cur_reg == cgsg_pkg::PH_TROT)
                            begin
                                if (div_rsp.rem >= p_eff - 16'd1 && cycle_count_reg < 3'd7)
                                begin
                                    cc_tmp = cycle_count_reg + 3'd1;
                                end
                                cycle_count_next = cc_tmp;
                                if (cc_tmp >= 3'd4)
                                begin
                                    phase_next = cgsg_pkg::PH_DONE;
                                end
                            end
                            div_req.start = 1'b1;
                            div_req.num   = NW'(div_rsp.rem) * NW'(cgsg_pkg::SEGS);
                            op_next       = OP_SEG;
                        end
                        OP_SEG:
                        begin
                            seg_next      = div_rsp.quo[2:0];
                            div_req.start = 1'b1;
                            div_req.num   = NW'({div_rsp.rem, 16'h0000});
                            op_next       = OP_FRAC;
                        end
                        OP_FRAC:
                        begin
                            uq_next    = div_rsp.quo[15:0];
                            state_next = S_U2;
                        end
                        OP_ALIGN:
                        begin
                            sum_v      = 24'(a_po) + quo_s;
                            res_next   = cgsg_pkg::sat16(sum_v);
                            state_next = S_EMIT;
                        end
                        OP_RAMP:
                        begin
                            sum_v      = 24'(b_st) + quo_s;
                            res_next   = cgsg_pkg::sat16(sum_v);
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_U2:
            begin
                mul_a      = MA_W'({1'b0, uq_reg});
                mul_b      = MB_W'({1'b0, uq_reg});
                state_next = S_U3;
            end
            S_U3:
            begin
                u2_next    = prod[31:16];
                mul_a      = MA_W'({1'b0, prod[31:16]});
                mul_b      = MB_W'({1'b0, uq_reg});
                state_next = S_UL;
            end
            S_UL:
            begin
                u3_next    = prod[31:16];
                j_next     = '0;
                state_next = S_C1;
            end
            S_C1:
            begin
                acc_next   = ACC_W'(p1) <<< 17;
                mul_a      = cf1;
                mul_b      = MB_W'({1'b0, uq_reg});
                state_next = S_C2;
            end
            S_C2:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                mul_a      = cf2;
                mul_b      = MB_W'({1'b0, u2_reg});
                state_next = S_C3;
            end
            S_C3:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                mul_a      = cf3;
                mul_b      = MB_W'({1'b0, u3_reg});
                state_next = S_C4;
            end
            S_C4:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = S_CQ;
            end
            S_CQ:
            begin
                q_next = q_val;
                if (ph_cur_reg == cgsg_pkg::PH_TRANS)
                begin
                    state_next = S_RMUL;
                end
                else
                begin
                    res_next   = cgsg_pkg::sat16(24'(q_val));
                    state_next = S_EMIT;
                end
            end
            S_RMUL:
            begin
                mul_a      = q_reg - b_st;
                mul_b      = MB_W'({1'b0, rs_reg});
                state_next = S_RDIV;
            end
            S_AMUL:
            begin
                mul_a      = b_st - a_po;
                mul_b      = MB_W'({1'b0, align_step_reg});
                state_next = S_ADIV;
            end
            S_ADIV, S_RDIV:
            begin
                neg_next      = prod[MP_W-1];
                div_req.start = 1'b1;
                div_req.den   = den_sel;
                div_req.num   = abs_prod[NW-1:0] + NW'(den_sel >> 1);
                op_next       = (state_reg == S_ADIV) ? OP_ALIGN : OP_RAMP;
                state_next    = S_DIVW;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_phase_next = ph_cur_reg;
                    out_fin_next   = fin_reg;
                    if (fin_reg)
                    begin
                        out_joint_next = '0;
                        out_angle_next = '0;
                        out_stiff_next = '0;
                        out_damp_next  = '0;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_joint_next = jj;
                        out_angle_next = res_reg;
                        out_stiff_next = stiff_reg;
                        out_damp_next  = damp_reg;
                        out_last_next  = (j_reg == JW'(JOINTS - 1));
                        if (j_reg == JW'(JOINTS - 1))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = (ph_cur_reg == cgsg_pkg::PH_ALIGN) ? S_AMUL : S_C1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_MOD;
            phase_reg       <= cgsg_pkg::PH_WAIT;
            ph_cur_reg      <= cgsg_pkg::PH_WAIT;
            align_ticks_reg <= 16'd500;
            ramp_ticks_reg  <= 16'd500;
            trot_ticks_reg  <= 16'd250;
            stiff_reg       <= '0;
            damp_reg        <= '0;
            align_step_reg  <= '0;
            ramp_step_reg   <= '0;
            trot_step_reg   <= '0;
            cycle_count_reg <= '0;
            mask_reg        <= '0;
            j_reg           <= '0;
            fin_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            phase_reg       <= phase_next;
            ph_cur_reg      <= ph_cur_next;
            align_step_reg  <= align_step_next;
            ramp_step_reg   <= ramp_step_next;
            trot_step_reg   <= trot_step_next;
            cycle_count_reg <= cycle_count_next;
            mask_reg        <= mask_next;
            j_reg           <= j_next;
            fin_reg         <= fin_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cgsg_pkg::CFG_ALIGN: align_ticks_reg <= cfg_data;
                    cgsg_pkg::CFG_RAMP:  ramp_ticks_reg  <= cfg_data;
                    cgsg_pkg::CFG_TROT:  trot_ticks_reg  <= cfg_data;
                    cgsg_pkg::CFG_STIFF: stiff_reg       <= cfg_data;
                    cgsg_pkg::CFG_DAMP:  damp_reg        <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        rs_reg        <= rs_next;
        uq_reg        <= uq_next;
        u2_reg        <= u2_next;
        u3_reg        <= u3_next;
        seg_reg       <= seg_next;
        acc_reg       <= acc_next;
        q_reg         <= q_next;
        res_reg       <= res_next;
        out_joint_reg <= out_joint_next;
        out_angle_reg <= out_angle_next;
        out_stiff_reg <= out_stiff_next;
        out_damp_reg  <= out_damp_next;
        out_phase_reg <= out_phase_next;
        out_fin_reg   <= out_fin_next;
        out_last_reg  <= out_last_next;
        if (store_we)
        begin
            measured_store_reg[joint_index[JW-1:0]] <= measured_angle;
        end
        if (capture)
        begin
            start_pose_reg <= measured_store_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign joint_number = out_joint_reg;
    assign target_angle = out_angle_reg;
    assign stiffness    = out_stiff_reg;
    assign damping      = out_damp_reg;
    assign phase        = out_phase_reg;
    assign finished     = out_fin_reg;
    assign last         = out_last_reg;

    `CGSG_ASSERT_IMP(a_div_busy_in_wait, div_rsp.busy, state_reg == S_DIVW, "divider busy outside wait")
    `CGSG_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_reg == S_DIVW, "divider done outside wait")
    `CGSG_ASSERT_IMP(a_finished_is_last, out_valid && finished, last, "done beat is not a last beat")
    `CGSG_ASSERT_IMP(a_last_joint, out_valid && last && !finished, joint_number == 4'(JOINTS - 1), "bad last")
    `CGSG_ASSERT_NXT(a_emit_loads, (state_reg == S_EMIT) && (!out_valid || out_ready), out_valid, "no load")
endmodule
